@@ sv/dwpr_pkg.sv @@
`default_nettype none
package dwpr_pkg;

  localparam int TICK_W = 16;
  localparam int LEVEL_W = 8;
  localparam int POT_W = 10;
  localparam int PROD_W = TICK_W + LEVEL_W;
  localparam int QUO_W = LEVEL_W + 1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TICK_W-1:0] RECOVER_RST = 16'd1500;
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;
  localparam logic [TICK_W-1:0] POT_FULL = 16'd1023;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_RECOVER = 1'b1;

  typedef struct packed {
    logic start;
    logic [PROD_W-1:0] dividend;
    logic [TICK_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ sv/dwpr_if.sv @@
`default_nettype none
interface dwpr_tick_if;
  logic valid;
  logic ready;
  logic button_level;
  logic [9:0] pot_sample;
  modport source (output valid, output button_level, output pot_sample, input ready);
  modport sink (input valid, input button_level, input pot_sample, output ready);
endinterface

interface dwpr_result_if;
  logic valid;
  logic ready;
  logic [7:0] led_level;
  logic ramping;
  logic [7:0] goal_level;
  modport source (output valid, output led_level, output ramping, output goal_level,
                  input ready);
  modport sink (input valid, input led_level, input ramping, input goal_level,
                output ready);
endinterface
`default_nettype wire

@@ sv/dwpr_div.sv @@
`default_nettype none
module dwpr_div
  import dwpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam int LOW_W = PROD_W - QUO_W;

  logic busy;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [TICK_W-1:0] rem;
  logic [QUO_W-1:0] dvd;
  logic [QUO_W-1:0] quo;
  logic [TICK_W-1:0] dvs;

  logic [TICK_W:0] trial;
  logic fits;
  logic [TICK_W:0] diff;

  always_comb begin
    trial = {rem, dvd[QUO_W-1]};
    fits = trial >= {1'b0, dvs};
    diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= TICK_W'(req.dividend[PROD_W-1:QUO_W]);
      dvd <= req.dividend[QUO_W-1:0];
      dvs <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      dvd <= {dvd[QUO_W-2:0], 1'b0};
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  // upper dividend bits are below the divisor, so the quotient fits QUO_W bits
  logic unused_ok;
  assign unused_ok = LOW_W > 0;

  always_comb begin
    rsp.done = done && unused_ok;
    rsp.quot = quo;
  end

endmodule
`default_nettype wire

@@ sv/dimmer_with_press_recovery_ramp.sv @@
`default_nettype none
// Button dimmer with press recovery ramp.
// tick (sink): one transfer per millisecond tick with the raw button level
// (0 = pressed) and a 10-bit pot sample. result (source): one transfer per
// tick with led_level, ramping and goal_level.
// APB port: debounce_ms at 0x0, recover_ms at 0x4; write only while idle.
// On a ramp tick the result takes a shift-add multiply, then a restoring
// divide, one quotient bit per cycle; while following the pot only the
// divide runs, and the tick that ends the ramp needs neither. One tick at
// a time: tick.ready rises again once the result is in the output
// register, so a new tick is not taken before the last one is done.
// If the receiver stalls, the result holds in the output register and the
// next tick is still taken and worked on; its result waits until the
// register frees.
// Reset: debounce 50, recover 1500, button seen released, brightness 0,
// no ramp; no clearing pass.
module dimmer_with_press_recovery_ramp
  import dwpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  dwpr_tick_if.sink        tick,
  dwpr_result_if.source    result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam int MCNT_W = $clog2(LEVEL_W);

  logic [1:0] state;
  logic [TICK_W-1:0] debounce_ms;
  logic [TICK_W-1:0] recover_ms;

  logic prev_raw_level;
  logic stable_level;
  logic [TICK_W-1:0] hold_ticks;
  logic in_recovery;
  logic [TICK_W-1:0] ramp_ticks;
  logic [LEVEL_W-1:0] saved_level;
  logic [LEVEL_W-1:0] current_level;

  logic [PROD_W-1:0] mul_acc;
  logic [PROD_W-1:0] mul_acc_next;
  logic [LEVEL_W-1:0] mul_bits;
  logic [TICK_W-1:0] mul_cand;
  logic [MCNT_W-1:0] mul_cnt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;
  logic raw;
  logic [TICK_W-1:0] hold_eff;
  logic [TICK_W-1:0] hold_next;
  logic flip;
  logic press;
  logic rec_now;
  logic [LEVEL_W-1:0] saved_next;
  logic [TICK_W-1:0] ramp_base;
  logic [TICK_W-1:0] ramp_next;
  logic ramp_end;
  logic out_free;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RECOVER) ? 32'(recover_ms) : 32'(debounce_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RST;
      recover_ms <= RECOVER_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DEBOUNCE: debounce_ms <= pwdata[TICK_W-1:0];
        REG_RECOVER:  recover_ms <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick.ready = (state == S_IDLE);
  assign accept = tick.valid && tick.ready;
  assign out_free = !result.valid || result.ready;

  always_comb begin
    raw = tick.button_level;
    hold_eff = (raw != prev_raw_level) ? '0 : hold_ticks;
    hold_next = (hold_eff == TICK_MAX) ? hold_eff : hold_eff + TICK_W'(1);
    flip = (hold_eff > debounce_ms) && (raw != stable_level);
    press = flip && !raw && !in_recovery;
    rec_now = in_recovery || press;
    saved_next = press ? current_level : saved_level;
    ramp_base = press ? '0 : ramp_ticks;
    ramp_next = (ramp_base == TICK_MAX) ? ramp_base : ramp_base + TICK_W'(1);
    ramp_end = ramp_base >= recover_ms;
    mul_acc_next = {mul_acc[PROD_W-2:0], 1'b0} +
                   (mul_bits[LEVEL_W-1] ? PROD_W'(mul_cand) : '0);
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = mul_acc_next;
    div_req.divisor = recover_ms;
    if (accept && !rec_now) begin
      div_req.start = 1'b1;
      div_req.dividend = PROD_W'({tick.pot_sample, 8'd0});
      div_req.divisor = POT_FULL;
    end else if (state == S_MUL && mul_cnt == MCNT_W'(LEVEL_W - 1)) begin
      div_req.start = 1'b1;
    end
  end

  dwpr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev_raw_level <= 1'b1;
      stable_level <= 1'b1;
      hold_ticks <= '0;
      in_recovery <= 1'b0;
      ramp_ticks <= '0;
      saved_level <= '0;
      current_level <= '0;
      result.valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            prev_raw_level <= raw;
            hold_ticks <= hold_next;
            if (flip) stable_level <= raw;
            saved_level <= saved_next;
            if (rec_now) begin
              ramp_ticks <= ramp_next;
              if (ramp_end) begin
                current_level <= saved_next;
                in_recovery <= 1'b0;
                state <= S_DONE;
              end else begin
                in_recovery <= 1'b1;
                state <= S_MUL;
              end
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          if (mul_cnt == MCNT_W'(LEVEL_W - 1)) state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            current_level <= div_rsp.quot[QUO_W-1] ? LEVEL_MAX
                                                   : div_rsp.quot[LEVEL_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ramp product, saved level bits MSB first
  always_ff @(posedge clk) begin
    if (accept) begin
      mul_acc <= '0;
      mul_bits <= saved_next;
      mul_cand <= ramp_base;
      mul_cnt <= '0;
    end else if (state == S_MUL) begin
      mul_acc <= mul_acc_next;
      mul_bits <= {mul_bits[LEVEL_W-2:0], 1'b0};
      mul_cnt <= mul_cnt + MCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.led_level <= current_level;
      result.ramping <= in_recovery;
      result.goal_level <= in_recovery ? saved_level : current_level;
    end
  end

  a_ramp_below_goal: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ramping |-> result.led_level <= result.goal_level)
    else $error("ramp level above goal");

  a_idle_goal: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ramping |-> result.led_level == result.goal_level)
    else $error("goal differs from level outside ramp");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tick.ready)
    else $error("tick taken while busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside divide step");

endmodule
`default_nettype wire

@@ test/tb_dimmer_with_press_recovery_ramp.sv @@
`timescale 1ns / 100ps
module tb_dimmer_with_press_recovery_ramp;
  import dwpr_pkg::*;

  typedef struct packed {
    logic button;
    logic [POT_W-1:0] pot;
  } tick_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] led;
    logic ramping;
    logic [LEVEL_W-1:0] goal;
  } led_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dwpr_tick_if tick_bus ();
  dwpr_result_if result_bus ();

  dimmer_with_press_recovery_ramp dut (
    .clk(clk),
    .rst(rst),
    .tick(tick_bus.sink),
    .result(result_bus.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  tick_item_t pending_ticks[$];
  led_result_t expected_levels[$];

  // predictor state
  logic [TICK_W-1:0] debounce_cfg = DEBOUNCE_RST;
  logic [TICK_W-1:0] recover_cfg = RECOVER_RST;
  logic btn_prev = 1'b1;
  logic btn_stable = 1'b1;
  logic [TICK_W-1:0] hold_cnt = '0;
  logic recovering = 1'b0;
  logic [TICK_W-1:0] ramp_cnt = '0;
  logic [LEVEL_W-1:0] goal_lvl = '0;
  logic [LEVEL_W-1:0] led_lvl = '0;

  bit full_rate = 1'b0;
  bit hold_request = 1'b0;
  bit hold_started = 1'b0;
  int unsigned hold_left;
  int unsigned tx_gap;
  int unsigned rx_wait;
  int unsigned errors = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void advance_dimmer(input logic raw, input logic [POT_W-1:0] pot);
    led_result_t r;
    int unsigned scaled;
    if (raw != btn_prev) hold_cnt = '0;
    if (hold_cnt > debounce_cfg && raw != btn_stable) begin
      btn_stable = raw;
      if (!raw && !recovering) begin
        goal_lvl = led_lvl;
        led_lvl = '0;
        recovering = 1'b1;
        ramp_cnt = '0;
      end
    end
    btn_prev = raw;
    if (hold_cnt != TICK_MAX) hold_cnt = hold_cnt + 1'b1;
    if (recovering) begin
      if (ramp_cnt >= recover_cfg) begin
        led_lvl = goal_lvl;
        recovering = 1'b0;
      end else begin
        scaled = (32'(ramp_cnt) * 32'(goal_lvl)) / 32'(recover_cfg);
        led_lvl = scaled[LEVEL_W-1:0];
      end
      if (ramp_cnt != TICK_MAX) ramp_cnt = ramp_cnt + 1'b1;
    end else begin
      scaled = (32'(pot) << 8) / 32'(POT_FULL);
      led_lvl = (scaled > 32'(LEVEL_MAX)) ? LEVEL_MAX : scaled[LEVEL_W-1:0];
    end
    r.led = led_lvl;
    r.ramping = recovering;
    r.goal = recovering ? goal_lvl : led_lvl;
    expected_levels.push_back(r);
  endfunction

  // tick source
  always @(posedge clk) begin : tick_driver
    tick_item_t nxt;
    if (rst) begin
      tick_bus.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (tick_bus.valid && tick_bus.ready)
        advance_dimmer(tick_bus.button_level, tick_bus.pot_sample);
      if (!tick_bus.valid || tick_bus.ready) begin
        if (tx_gap != 0) begin
          tick_bus.valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          tick_bus.valid <= 1'b1;
          tick_bus.button_level <= nxt.button;
          tick_bus.pot_sample <= nxt.pot;
          tx_gap <= full_rate ? 0 : $urandom_range(0, 4);
        end else begin
          tick_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_started) begin
      hold_left <= 400;
      hold_started <= 1'b1;
    end
  end

  // result sink and checker
  always @(posedge clk) begin : result_monitor
    int unsigned w;
    led_result_t want;
    if (rst) begin
      result_bus.ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (result_bus.valid && result_bus.ready) begin
        if (expected_levels.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("unexpected result: led %0d ramping %0d goal %0d",
                     result_bus.led_level, result_bus.ramping, result_bus.goal_level);
        end else begin
          want = expected_levels.pop_front();
          if (result_bus.led_level !== want.led || result_bus.ramping !== want.ramping ||
              result_bus.goal_level !== want.goal) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch (exp/got): led %0d/%0d ramping %0d/%0d goal %0d/%0d",
                       want.led, result_bus.led_level, want.ramping, result_bus.ramping,
                       want.goal, result_bus.goal_level);
          end
        end
        w = full_rate ? 0 : $urandom_range(0, 4);
      end else if (w != 0) begin
        w = w - 1;
      end
      rx_wait <= w;
      result_bus.ready <= (w == 0) && (hold_left == 0);
    end
  end

  task automatic add_tick(input logic button, input logic [POT_W-1:0] pot);
    tick_item_t t;
    t.button = button;
    t.pot = pot;
    pending_ticks.push_back(t);
  endtask

  function automatic logic [POT_W-1:0] pick_pot();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 10'd1023;
      2: return 10'($urandom_range(1018, 1023));
      3: return 10'd1;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // mostly held levels, long enough to debounce unless the 60-tick cap cuts them, some bouncing
  task automatic queue_ticks(input int unsigned dcfg, input int unsigned count);
    int unsigned n;
    int unsigned len;
    int unsigned k;
    logic lvl;
    n = 0;
    lvl = 1'b0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        len = dcfg + 2 + $urandom_range(0, 8);
        if (len > 60) len = 60;
        for (k = 0; k < len; k++) add_tick(lvl, pick_pot());
        lvl = !lvl;
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) add_tick(1'($urandom_range(0, 1)), pick_pot());
      end
      n += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() != 0 || tick_bus.valid || expected_levels.size() != 0)
      @(negedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [TICK_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_DEBOUNCE) debounce_cfg = value;
    else recover_cfg = value;
  endtask

  task automatic set_phase(input logic [TICK_W-1:0] dcfg, input logic [TICK_W-1:0] rcfg,
                           input bit fast);
    wait_drained();
    write_reg(REG_DEBOUNCE, dcfg);
    write_reg(REG_RECOVER, rcfg);
    @(negedge clk);
    full_rate = fast;
  endtask

  initial begin
    rst = 1'b1;
    tick_bus.valid = 1'b0;
    tick_bus.button_level = 1'b1;
    tick_bus.pot_sample = '0;
    result_bus.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pot scaling extremes at reset settings, then a short bounce
    add_tick(1'b1, 10'd0);
    add_tick(1'b1, 10'd1);
    add_tick(1'b1, 10'd511);
    add_tick(1'b1, 10'd512);
    add_tick(1'b1, 10'd1019);
    add_tick(1'b1, 10'd1020);
    add_tick(1'b1, 10'd1022);
    add_tick(1'b1, 10'd1023);
    add_tick(1'b0, 10'd1023);
    add_tick(1'b1, 10'd700);

    // no debounce, no ramp: press restores the goal at once
    set_phase(16'd0, 16'd0, 1'b0);
    add_tick(1'b0, 10'd1023);
    add_tick(1'b0, 10'd1023);
    add_tick(1'b1, 10'd0);
    add_tick(1'b1, 10'd0);
    queue_ticks(0, 150);

    // press, release and press again during the ramp
    set_phase(16'd1, 16'd10, 1'b0);
    add_tick(1'b1, 10'd1023);
    add_tick(1'b0, 10'd1023);
    add_tick(1'b0, 10'd1023);
    add_tick(1'b0, 10'd1023);
    add_tick(1'b1, 10'd3);
    add_tick(1'b1, 10'd0);
    add_tick(1'b1, 10'd1023);
    add_tick(1'b0, 10'd512);
    add_tick(1'b0, 10'd0);
    add_tick(1'b0, 10'd1023);
    queue_ticks(1, 250);

    set_phase(16'd2, 16'd30, 1'b1);
    queue_ticks(2, 300);

    set_phase(16'd2, 16'd30, 1'b0);
    hold_request = 1'b1;
    queue_ticks(2, 150);

    set_phase(16'hFFFF, 16'hFFFF, 1'b0);
    queue_ticks(16'hFFFF, 40);

    set_phase(16'd0, 16'hFFFF, 1'b0);
    queue_ticks(0, 150);

    set_phase(16'd3, 16'd1, 1'b0);
    queue_ticks(3, 250);

    set_phase(16'd1, 16'd255, 1'b0);
    queue_ticks(1, 250);

    set_phase(16'd5, 16'd12, 1'b0);
    queue_ticks(5, 250);

    set_phase(DEBOUNCE_RST, RECOVER_RST, 1'b0);
    queue_ticks(DEBOUNCE_RST, 100);

    wait_drained();
    if (errors == 0 && expected_levels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/dwpr_pkg.sv
sv/dwpr_if.sv
sv/dwpr_div.sv
sv/dimmer_with_press_recovery_ramp.sv
test/tb_dimmer_with_press_recovery_ramp.sv
